[design/bbs_pkg.sv]
package bbs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int DIV_STEPS     = 17;

  typedef struct packed {
    logic        cmd;
    logic [15:0] grav_x_in;
    logic [15:0] grav_y_in;
    logic [15:0] material_in;
    logic [15:0] speed_in;
    logic [9:0]  gate_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] speed_out;
    logic        hit_x;
    logic        hit_y;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUND_X  = 2'd0,
    REG_BOUND_Y  = 2'd1,
    REG_GATE_THR = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_BUMP, OP_MTT, OP_ST2, OP_MGXT2, OP_X1, OP_X2, OP_Y1, OP_Y2,
    OP_WCLAMP, OP_WV1, OP_WV2, OP_WM1, OP_WM2, OP_WM3, OP_MGXT, OP_FVY,
    OP_SQ1, OP_SQ2, OP_SQ3, OP_SPDMAX, OP_SQINIT, OP_SQSTEP,
    OP_DINIT, OP_DSTEP, OP_DSTORE, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DSEL_SPD, DSEL_X, DSEL_Y
  } dsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MTT, S_ST2, S_MGXT2, S_X1, S_X2, S_Y1, S_Y2, S_CHKX, S_CHKY,
    S_WCL, S_WV1, S_WV2, S_WM1, S_WM2, S_WM3, S_F1, S_F2, S_F3,
    S_SQ1, S_SQ2, S_SQ3, S_DEC, S_SQ, S_DINIT, S_DSTEP, S_DSTORE, S_EMIT
  } state_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    logic  refl_y;
  } ctl_t;

  typedef struct packed {
    logic x_out;
    logic y_out;
    logic big;
    logic out_busy;
  } sts_t;

endpackage

[design/bouncing_ball_step_unit.sv]
// Bouncing ball step unit: a ball in the box [-bound_x, bound_x] x [-bound_y, bound_y]
// under two-axis gravity, in signed fixed point with FRAC_BITS fraction bits. An
// advance word (cmd 0) evaluates 0.5*g*t^2 + v*t + origin, bounces off walls with
// the elasticity factor and returns one result word: position as a fraction of
// the box, speed clamped to 20 as a fraction of 20, and wall-hit flags. A bump
// word (cmd 1) gives no result; if gate_value > gate_threshold it restarts the
// ball at the center with velocity (10, -10). One word is worked on at a time by
// a sequencer around one shared 33x33 multiplier, a bit-serial square root and a
// one-bit-per-cycle divider for the positions. An advance runs the multiply steps,
// more of them per wall hit, FRAC_BITS + 5 square-root steps and a reciprocal scale
// for the speed (both skipped when the speed is 20 or more), and a division each for
// x and y. The next word is taken as soon as the result moves to the output register,
// even while that result waits.
// Configuration is a plain write port; the user must write it only while idle, and
// the block itself does not enforce this.
module bouncing_ball_step_unit #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bbs_pkg::in_word_t             in_word,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output bbs_pkg::out_word_t            out_word,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [bbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbs_pkg::CFG_W-1:0]     cfg_data
);

  bbs_pkg::ctl_t ctl;  // op plus divider select and wall axis
  bbs_pkg::sts_t sts;  // wall tests, speed limit, output stall

  // sequencer
  bbs_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_word.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // arithmetic, ball state, config and output register
  bbs_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

[design/bbs_ctrl.sv]
module bbs_ctrl #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_cmd,
  output logic          in_ready,
  input  bbs_pkg::sts_t sts,
  output bbs_pkg::ctl_t ctl
);

  localparam int SQ_STEPS = FRAC_BITS + 5;
  localparam int CNT_MAX  = (SQ_STEPS - 1 > bbs_pkg::DIV_STEPS - 1) ?
                            SQ_STEPS - 1 : bbs_pkg::DIV_STEPS - 1;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);

  bbs_pkg::state_t state, state_next;
  bbs_pkg::dsel_t  dsel;
  logic            on_y;
  logic [CNT_W-1:0] cnt;

  assign in_ready = !rst && (state == bbs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbs_pkg::S_IDLE;
      on_y  <= 1'b0;
      dsel  <= bbs_pkg::DSEL_SPD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        bbs_pkg::S_CHKX: on_y <= 1'b0;
        bbs_pkg::S_CHKY: on_y <= 1'b1;
        bbs_pkg::S_DEC: begin
          dsel <= sts.big ? bbs_pkg::DSEL_X : bbs_pkg::DSEL_SPD;
          cnt  <= CNT_W'(SQ_STEPS - 1);
        end
        bbs_pkg::S_SQ:    cnt <= cnt - 1'b1;
        bbs_pkg::S_DINIT: cnt <= CNT_W'(bbs_pkg::DIV_STEPS - 1);
        bbs_pkg::S_DSTEP: cnt <= cnt - 1'b1;
        bbs_pkg::S_DSTORE: dsel <= (dsel == bbs_pkg::DSEL_SPD) ? bbs_pkg::DSEL_X
                                                              : bbs_pkg::DSEL_Y;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bbs_pkg::S_IDLE:   if (in_valid) state_next = in_cmd ? bbs_pkg::S_IDLE : bbs_pkg::S_MTT;
      bbs_pkg::S_MTT:    state_next = bbs_pkg::S_ST2;
      bbs_pkg::S_ST2:    state_next = bbs_pkg::S_MGXT2;
      bbs_pkg::S_MGXT2:  state_next = bbs_pkg::S_X1;
      bbs_pkg::S_X1:     state_next = bbs_pkg::S_X2;
      bbs_pkg::S_X2:     state_next = bbs_pkg::S_Y1;
      bbs_pkg::S_Y1:     state_next = bbs_pkg::S_Y2;
      bbs_pkg::S_Y2:     state_next = bbs_pkg::S_CHKX;
      bbs_pkg::S_CHKX:   state_next = sts.x_out ? bbs_pkg::S_WCL : bbs_pkg::S_CHKY;
      bbs_pkg::S_CHKY:   state_next = sts.y_out ? bbs_pkg::S_WCL : bbs_pkg::S_F1;
      bbs_pkg::S_WCL:    state_next = bbs_pkg::S_WV1;
      bbs_pkg::S_WV1:    state_next = bbs_pkg::S_WV2;
      bbs_pkg::S_WV2:    state_next = bbs_pkg::S_WM1;
      bbs_pkg::S_WM1:    state_next = bbs_pkg::S_WM2;
      bbs_pkg::S_WM2:    state_next = bbs_pkg::S_WM3;
      bbs_pkg::S_WM3:    state_next = on_y ? bbs_pkg::S_F1 : bbs_pkg::S_CHKY;
      bbs_pkg::S_F1:     state_next = bbs_pkg::S_F2;
      bbs_pkg::S_F2:     state_next = bbs_pkg::S_F3;
      bbs_pkg::S_F3:     state_next = bbs_pkg::S_SQ1;
      bbs_pkg::S_SQ1:    state_next = bbs_pkg::S_SQ2;
      bbs_pkg::S_SQ2:    state_next = bbs_pkg::S_SQ3;
      bbs_pkg::S_SQ3:    state_next = bbs_pkg::S_DEC;
      bbs_pkg::S_DEC:    state_next = sts.big ? bbs_pkg::S_DINIT : bbs_pkg::S_SQ;
      bbs_pkg::S_SQ:     if (cnt == '0) state_next = bbs_pkg::S_DSTORE;
      bbs_pkg::S_DINIT:  state_next = bbs_pkg::S_DSTEP;
      bbs_pkg::S_DSTEP:  if (cnt == '0) state_next = bbs_pkg::S_DSTORE;
      bbs_pkg::S_DSTORE: state_next = (dsel == bbs_pkg::DSEL_Y) ? bbs_pkg::S_EMIT
                                                              : bbs_pkg::S_DINIT;
      bbs_pkg::S_EMIT:   if (!sts.out_busy) state_next = bbs_pkg::S_IDLE;
      default:           state_next = bbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op     = bbs_pkg::OP_NOP;
    ctl.dsel   = dsel;
    ctl.refl_y = on_y;
    case (state)
      bbs_pkg::S_IDLE:   if (in_valid) ctl.op = in_cmd ? bbs_pkg::OP_BUMP : bbs_pkg::OP_LOAD;
      bbs_pkg::S_MTT:    ctl.op = bbs_pkg::OP_MTT;
      bbs_pkg::S_ST2:    ctl.op = bbs_pkg::OP_ST2;
      bbs_pkg::S_MGXT2:  ctl.op = bbs_pkg::OP_MGXT2;
      bbs_pkg::S_X1:     ctl.op = bbs_pkg::OP_X1;
      bbs_pkg::S_X2:     ctl.op = bbs_pkg::OP_X2;
      bbs_pkg::S_Y1:     ctl.op = bbs_pkg::OP_Y1;
      bbs_pkg::S_Y2:     ctl.op = bbs_pkg::OP_Y2;
      bbs_pkg::S_WCL:    ctl.op = bbs_pkg::OP_WCLAMP;
      bbs_pkg::S_WV1:    ctl.op = bbs_pkg::OP_WV1;
      bbs_pkg::S_WV2:    ctl.op = bbs_pkg::OP_WV2;
      bbs_pkg::S_WM1:    ctl.op = bbs_pkg::OP_WM1;
      bbs_pkg::S_WM2:    ctl.op = bbs_pkg::OP_WM2;
      bbs_pkg::S_WM3:    ctl.op = bbs_pkg::OP_WM3;
      bbs_pkg::S_F1:     ctl.op = bbs_pkg::OP_MGXT;
      bbs_pkg::S_F2:     ctl.op = bbs_pkg::OP_WV1;
      bbs_pkg::S_F3:     ctl.op = bbs_pkg::OP_FVY;
      bbs_pkg::S_SQ1:    ctl.op = bbs_pkg::OP_SQ1;
      bbs_pkg::S_SQ2:    ctl.op = bbs_pkg::OP_SQ2;
      bbs_pkg::S_SQ3:    ctl.op = bbs_pkg::OP_SQ3;
      bbs_pkg::S_DEC:    ctl.op = sts.big ? bbs_pkg::OP_SPDMAX : bbs_pkg::OP_SQINIT;
      bbs_pkg::S_SQ:     ctl.op = bbs_pkg::OP_SQSTEP;
      bbs_pkg::S_DINIT:  ctl.op = bbs_pkg::OP_DINIT;
      bbs_pkg::S_DSTEP:  ctl.op = bbs_pkg::OP_DSTEP;
      bbs_pkg::S_DSTORE: ctl.op = bbs_pkg::OP_DSTORE;
      bbs_pkg::S_EMIT:   if (!sts.out_busy) ctl.op = bbs_pkg::OP_EMIT;
      default:           ctl.op = bbs_pkg::OP_NOP;
    endcase
  end

endmodule

[design/bbs_datapath.sv]
module bbs_datapath #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bbs_pkg::ctl_t                  ctl,
  output bbs_pkg::sts_t                  sts,
  input  bbs_pkg::in_word_t              in_word,
  input  logic                           cfg_we,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbs_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bbs_pkg::out_word_t             out_word
);

  localparam int BQW = 12 + FRAC_BITS;
  localparam int DW  = 13 + FRAC_BITS;
  localparam int RW  = 14 + FRAC_BITS;
  localparam int SQW = 2 * FRAC_BITS + 10;
  localparam int CW  = (BQW + 2 > 34) ? BQW + 2 : 34;
  localparam int MW  = 33;
  localparam int PW  = 2 * MW;
  localparam int SPD_SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SPD_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic signed [31:0] HALF = 32'sh1 << (FRAC_BITS - 1);
  localparam logic signed [31:0] TEN  = 32'sh0a << FRAC_BITS;
  localparam logic [63:0]        LIM2 = 64'd400 << (2 * FRAC_BITS);
  localparam logic [18:0]        DIV5_RECIP = 19'd419431;  // ceil(2^21 / 5)
  localparam logic signed [CW-1:0] C_MAX = CW'(32'sh7fffffff);
  localparam logic signed [CW-1:0] C_MIN = CW'(32'sh80000000);

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > C_MAX)      r = 32'sh7fffffff;
    else if (v < C_MIN) r = 32'sh80000000;
    else                r = v[31:0];
    return r;
  endfunction

  // config
  logic [11:0] bound_x, bound_y;
  logic [9:0]  gate_thr;

  // ball state
  logic [30:0]        tim;
  logic signed [31:0] vel_x, vel_y, origin_x, origin_y;

  // per-step working registers
  logic signed [31:0] gx, gy, el, t2, hs, x, y, vx, vy;
  logic [FRAC_BITS+1:0] inc;
  logic hx, hy;
  logic signed [PW-1:0] prod;
  logic [63:0] sum;
  logic [SQW-1:0] sq_n, sq_r, sq_b;
  logic [RW-1:0] rem;
  logic [DW-1:0] den;
  logic [16:0] quo;
  logic [15:0] pos_x, pos_y, spd;

  // input conversion
  logic [16+FRAC_BITS-1:0] gxs, gys, mats, spds;
  logic signed [31:0] gx_n, gy_n, el_n;
  assign gxs  = {in_word.grav_x_in, {FRAC_BITS{1'b0}}};
  assign gys  = {in_word.grav_y_in, {FRAC_BITS{1'b0}}};
  assign mats = {in_word.material_in, {FRAC_BITS{1'b0}}};
  assign spds = {in_word.speed_in, {FRAC_BITS{1'b0}}};
  assign gx_n = 32'(signed'({1'b0, gxs[16+FRAC_BITS-1:16]})) - HALF;
  assign gy_n = 32'(signed'({1'b0, gys[16+FRAC_BITS-1:16]})) - HALF;
  assign el_n = 32'(signed'({1'b0, mats[16+FRAC_BITS-1:17]})) + HALF;

  // shared multiplier, floored and saturated Q result
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] psh;
  logic signed [31:0]   mq;
  logic signed [MW-1:0] tim_m, vxe, vye, uxa, uya;
  assign psh   = prod >>> FRAC_BITS;
  assign mq    = (psh > PW'(32'sh7fffffff)) ? 32'sh7fffffff :
                 (psh < PW'(32'sh80000000)) ? 32'sh80000000 : psh[31:0];
  assign tim_m = MW'({2'b00, tim});
  assign vxe   = MW'(vx);
  assign vye   = MW'(vy);
  assign uxa   = (vxe < 0) ? -vxe : vxe;
  assign uya   = (vye < 0) ? -vye : vye;

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.op)
      bbs_pkg::OP_MTT:    begin ma = tim_m;      mb = tim_m;      end
      bbs_pkg::OP_MGXT2:  begin ma = MW'(gx);    mb = MW'(t2);    end
      bbs_pkg::OP_X1:     begin ma = MW'(vel_x); mb = tim_m;      end
      bbs_pkg::OP_X2:     begin ma = MW'(gy);    mb = MW'(t2);    end
      bbs_pkg::OP_Y1:     begin ma = MW'(vel_y); mb = tim_m;      end
      bbs_pkg::OP_WCLAMP,
      bbs_pkg::OP_MGXT:   begin ma = MW'(gx);    mb = tim_m;      end
      bbs_pkg::OP_WV1:    begin ma = MW'(gy);    mb = tim_m;      end
      bbs_pkg::OP_WM1:    begin ma = ctl.refl_y ? vxe : -vxe; mb = MW'(el); end
      bbs_pkg::OP_WM2:    begin ma = ctl.refl_y ? -vye : vye; mb = MW'(el); end
      bbs_pkg::OP_SQ1:    begin ma = uxa;        mb = uxa;        end
      bbs_pkg::OP_SQ2:    begin ma = uya;        mb = uya;        end
      default: ;
    endcase
  end

  // wall tests and clamps
  logic signed [CW-1:0] bqx_w, bqy_w, x_w, y_w;
  logic x_lo, x_hi, y_lo, y_hi;
  assign bqx_w = signed'(CW'(bound_x)) <<< FRAC_BITS;
  assign bqy_w = signed'(CW'(bound_y)) <<< FRAC_BITS;
  assign x_w   = CW'(x);
  assign y_w   = CW'(y);
  assign x_lo  = x_w < -bqx_w;
  assign x_hi  = x_w > bqx_w;
  assign y_lo  = y_w < -bqy_w;
  assign y_hi  = y_w > bqy_w;

  assign sts.x_out    = x_lo || x_hi;
  assign sts.y_out    = y_lo || y_hi;
  assign sts.big      = sum >= LIM2;
  assign sts.out_busy = out_valid && !out_ready;

  // sqrt and divider steps
  logic [SQW-1:0] sq_trial;
  logic           sq_ge, dv_ge;
  logic [RW-1:0]  dv_sub;
  logic [15:0]    quo_sat;
  logic [32:0]    tim_sum;
  assign sq_trial = sq_r + sq_b;
  assign sq_ge    = sq_n >= sq_trial;
  assign dv_ge    = rem >= RW'(den);
  assign dv_sub   = dv_ge ? rem - RW'(den) : rem;
  assign quo_sat  = quo[16] ? 16'hffff : quo[15:0];
  assign tim_sum  = 33'(tim) + 33'(inc);

  // speed scale: root / (20 << FRAC_BITS) * 65536 is the root at 16 fraction
  // bits over 20, done as a shift by 2 and a reciprocal multiply for /5
  logic [20:0] spd_x;
  logic [37:0] spd_prod;
  assign spd_x    = 21'((sq_r >> SPD_SHR) << SPD_SHL);
  assign spd_prod = 38'(spd_x[20:2]) * 38'(DIV5_RECIP);

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      bound_x   <= 12'd500;
      bound_y   <= 12'd500;
      gate_thr  <= 10'd400;
      tim       <= '0;
      vel_x     <= '0;
      vel_y     <= '0;
      origin_x  <= '0;
      origin_y  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bbs_pkg::REG_BOUND_X:  bound_x  <= cfg_data;
          bbs_pkg::REG_BOUND_Y:  bound_y  <= cfg_data;
          bbs_pkg::REG_GATE_THR: gate_thr <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (ctl.op == bbs_pkg::OP_EMIT) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
      case (ctl.op)
        bbs_pkg::OP_LOAD: begin
          gx  <= gx_n;
          gy  <= gy_n;
          el  <= el_n;
          inc <= spds[16+FRAC_BITS-1:14];
          hx  <= 1'b0;
          hy  <= 1'b0;
        end
        bbs_pkg::OP_BUMP: begin
          if (in_word.gate_value > gate_thr) begin
            tim      <= '0;
            vel_x    <= TEN;
            vel_y    <= -TEN;
            origin_x <= '0;
            origin_y <= '0;
          end
        end
        bbs_pkg::OP_ST2: t2 <= mq;
        bbs_pkg::OP_X1:  hs <= mq >>> 1;
        bbs_pkg::OP_X2:  x  <= sat32(CW'(hs) + CW'(mq) + CW'(origin_x));
        bbs_pkg::OP_Y1:  hs <= mq >>> 1;
        bbs_pkg::OP_Y2:  y  <= sat32(CW'(hs) + CW'(mq) + CW'(origin_y));
        bbs_pkg::OP_WCLAMP: begin
          if (!ctl.refl_y) begin
            x        <= sat32(x_lo ? -bqx_w : bqx_w);
            origin_x <= sat32(x_lo ? -bqx_w : bqx_w);
            origin_y <= y;
            hx       <= (gx != 0);
          end else begin
            y        <= sat32(y_lo ? -bqy_w : bqy_w);
            origin_x <= x;
            origin_y <= sat32(y_lo ? -bqy_w : bqy_w);
            hy       <= 1'b1;
          end
        end
        bbs_pkg::OP_WV1: vx <= sat32(CW'(mq) + CW'(vel_x));
        bbs_pkg::OP_WV2: begin
          vy  <= sat32(CW'(mq) + CW'(vel_y));
          tim <= '0;
        end
        bbs_pkg::OP_FVY: vy    <= sat32(CW'(mq) + CW'(vel_y));
        bbs_pkg::OP_WM2: vel_x <= mq;
        bbs_pkg::OP_WM3: vel_y <= mq;
        bbs_pkg::OP_SQ1: tim   <= tim_sum[32:31] != 2'b00 ? 31'h7fffffff : tim_sum[30:0];
        bbs_pkg::OP_SQ2: sum   <= prod[63:0];
        bbs_pkg::OP_SQ3: sum   <= sum + prod[63:0];
        bbs_pkg::OP_SPDMAX: spd <= 16'hffff;
        bbs_pkg::OP_SQINIT: begin
          sq_n <= sum[SQW-1:0];
          sq_r <= '0;
          sq_b <= SQW'(1) << (SQW - 2);
        end
        bbs_pkg::OP_SQSTEP: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_trial;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
        end
        bbs_pkg::OP_DINIT: begin
          quo <= '0;
          case (ctl.dsel)
            bbs_pkg::DSEL_X: begin
              rem <= RW'(x_w + bqx_w);
              den <= DW'(bound_x) << (FRAC_BITS + 1);
            end
            default: begin
              rem <= RW'(y_w + bqy_w);
              den <= DW'(bound_y) << (FRAC_BITS + 1);
            end
          endcase
        end
        bbs_pkg::OP_DSTEP: begin
          rem <= dv_sub << 1;
          quo <= {quo[15:0], dv_ge};
        end
        bbs_pkg::OP_DSTORE: begin
          case (ctl.dsel)
            bbs_pkg::DSEL_SPD: spd   <= spd_prod[36:21];
            bbs_pkg::DSEL_X:   pos_x <= (bound_x == '0) ? 16'h8000 : quo_sat;
            default:           pos_y <= (bound_y == '0) ? 16'h8000 : quo_sat;
          endcase
        end
        bbs_pkg::OP_EMIT: begin
          out_word.pos_x     <= pos_x;
          out_word.pos_y     <= pos_y;
          out_word.speed_out <= spd;
          out_word.hit_x     <= hx;
          out_word.hit_y     <= hy;
        end
        default: ;
      endcase
    end
  end

endmodule

[test/tb_bouncing_ball_step_unit.sv]
module tb_bouncing_ball_step_unit;

  localparam int FB = bbs_pkg::FRAC_BITS_DEF;
  // index past the last register; writes to it must be dropped
  localparam logic [bbs_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 250;   // one advance with two wall hits, plus margin
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bbs_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bbs_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [bbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbs_pkg::CFG_W-1:0] cfg_data = '0;

  bouncing_ball_step_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ball state mirrored by the predictor
  longint ball_t, ball_vx, ball_vy, ball_ox, ball_oy;
  int unsigned box_x, box_y, bump_thr;

  bbs_pkg::out_word_t ball_results[$];
  int mismatches = 0;
  bit idle_on = 1'b1;     // random gaps on both sides
  bit hold_req = 1'b0;    // asks the receiver for one long hold-off
  int quiet = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> FB);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] box_frac(longint p, longint bq);
    longint unsigned q;
    if (bq <= 0) return 16'd32768;
    q = (longint'(p + bq) << 16) / (bq * 2);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // advances the mirrored ball by one accepted word
  task automatic predict_ball(input bbs_pkg::in_word_t w);
    longint half, gx, gy, el, inc, t, t2, x, y, bqx, bqy, vx, vy;
    longint unsigned ux, uy, sum, lim, spd;
    bbs_pkg::out_word_t r;
    half = longint'(1) << (FB - 1);
    if (w.cmd) begin
      if (w.gate_value > bump_thr) begin
        ball_t = 0;
        ball_vx = longint'(10) << FB;
        ball_vy = -(longint'(10) << FB);
        ball_ox = 0;
        ball_oy = 0;
      end
      return;
    end
    r = '0;
    gx = longint'(w.grav_x_in) - half;
    gy = longint'(w.grav_y_in) - half;
    el = (longint'(w.material_in) >>> 1) + half;
    inc = longint'(w.speed_in) << 2;
    t = ball_t;
    t2 = qmul(t, t);
    x = sat32((qmul(gx, t2) >>> 1) + qmul(ball_vx, t) + ball_ox);
    y = sat32((qmul(gy, t2) >>> 1) + qmul(ball_vy, t) + ball_oy);
    bqx = longint'(box_x) << FB;
    bqy = longint'(box_y) << FB;
    // side wall first; a top/bottom hit in the same step then runs at t = 0
    if (x < -bqx || x > bqx) begin
      x = sat32(x < -bqx ? -bqx : bqx);
      ball_ox = x;
      ball_oy = y;
      vx = sat32(qmul(gx, t) + ball_vx);
      vy = sat32(qmul(gy, t) + ball_vy);
      t = 0;
      ball_vx = qmul(-vx, el);
      ball_vy = qmul(vy, el);
      r.hit_x = (gx != 0);
    end
    if (y < -bqy || y > bqy) begin
      y = sat32(y < -bqy ? -bqy : bqy);
      ball_ox = x;
      ball_oy = y;
      vx = sat32(qmul(gx, t) + ball_vx);
      vy = sat32(qmul(gy, t) + ball_vy);
      t = 0;
      ball_vx = qmul(vx, el);
      ball_vy = qmul(-vy, el);
      r.hit_y = 1'b1;
    end
    vx = sat32(qmul(gx, t) + ball_vx);
    vy = sat32(qmul(gy, t) + ball_vy);
    ux = (vx < 0) ? -vx : vx;
    uy = (vy < 0) ? -vy : vy;
    sum = ux * ux + uy * uy;
    lim = longint'(20) << FB;
    if (sum >= lim * lim) spd = 65535;
    else begin
      spd = (int_sqrt(sum) << 16) / lim;
      if (spd > 65535) spd = 65535;
    end
    ball_t = sat32(t + inc);
    r.pos_x = box_frac(x, bqx);
    r.pos_y = box_frac(y, bqy);
    r.speed_out = spd[15:0];
    ball_results.push_back(r);
  endtask

  // one word on the input channel; returns at the falling edge after acceptance
  task automatic send_word(input bbs_pkg::in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    predict_ball(w);
    @(negedge clk);
  endtask

  task automatic send_advance(input logic [15:0] gx, gy, mat, spd);
    bbs_pkg::in_word_t w;
    w = '{cmd: 1'b0, grav_x_in: gx, grav_y_in: gy, material_in: mat,
          speed_in: spd, gate_value: 10'($urandom)};
    send_word(w);
  endtask

  task automatic send_bump(input logic [9:0] gate);
    bbs_pkg::in_word_t w;
    w = bbs_pkg::in_word_t'($bits(bbs_pkg::in_word_t)'({$urandom, $urandom, $urandom}));
    w.cmd = 1'b1;
    w.gate_value = gate;
    send_word(w);
  endtask

  // stop offering, let every result arrive and the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (ball_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // registers only change while the block is idle
  task automatic write_regs(input int unsigned bx, by, thr);
    drain();
    cfg_we <= 1'b1; cfg_index <= bbs_pkg::REG_BOUND_X; cfg_data <= bbs_pkg::CFG_W'(bx);
    @(negedge clk);
    cfg_index <= bbs_pkg::REG_BOUND_Y; cfg_data <= bbs_pkg::CFG_W'(by);
    @(negedge clk);
    cfg_index <= bbs_pkg::REG_GATE_THR; cfg_data <= bbs_pkg::CFG_W'(thr);
    @(negedge clk);
    cfg_index <= REG_SPARE; cfg_data <= bbs_pkg::CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    box_x = bx & 12'hFFF;
    box_y = by & 12'hFFF;
    bump_thr = thr & 10'h3FF;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly: bump the ball, then let it fly for a while with random controls
  task automatic random_flights(input int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 9))
        0: send_bump(10'($urandom));                       // noise bump
        1, 2: send_bump(10'($urandom_range(bump_thr + 1 > 1023 ? 1023 : bump_thr + 1, 1023)));
        default: send_advance(rand_field(), rand_field(), rand_field(), rand_field());
      endcase
      sent++;
    end
  endtask

  task automatic test_directed();
    send_advance(16'h8000, 16'h8000, 16'h0000, 16'h0000);   // at rest
    send_advance(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // extremes
    send_advance(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_bump(10'd400);                                     // not above threshold
    send_advance(16'h8000, 16'h8000, 16'h8000, 16'h4000);
    send_bump(10'd401);                                     // restart
    repeat (6) send_advance(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_bump(10'd1023);
    repeat (6) send_advance(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_corner_boxes();
    // tiny box: both walls in one step, full-scale speed
    write_regs(1, 1, 0);
    send_bump(10'd0);                                       // gate equal to threshold
    send_bump(10'd1);
    repeat (5) send_advance(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    // zero bounds: positions pinned to the center code
    write_regs(0, 0, 1023);
    send_bump(10'd1023);                                    // never above 1023
    repeat (4) send_advance(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
    write_regs(4095, 4095, 0);
    send_bump(10'd5);
    repeat (5) send_advance(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_random_boxes();
    repeat (8) begin
      write_regs($urandom_range(1, 4095), $urandom_range(1, 60), $urandom_range(0, 1023));
      random_flights(150);
    end
    write_regs(500, 500, 400);
    random_flights(150);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    while (hold_req) begin
      send_advance(rand_field(), rand_field(), rand_field(), rand_field());
    end
    random_flights(40);
  endtask

  task automatic test_no_gaps();
    drain();
    idle_on = 1'b0;
    write_regs(20, 3000, 100);
    random_flights(200);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    bbs_pkg::out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (ball_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_w = ball_results.pop_front();
        if (out_word !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pos %0d,%0d spd %0d hit %b%b",
                      " / got pos %0d,%0d spd %0d hit %b%b"},
                     exp_w.pos_x, exp_w.pos_y, exp_w.speed_out, exp_w.hit_x, exp_w.hit_y,
                     out_word.pos_x, out_word.pos_y, out_word.speed_out,
                     out_word.hit_x, out_word.hit_y);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    ball_t = 0; ball_vx = 0; ball_vy = 0; ball_ox = 0; ball_oy = 0;
    box_x = 500; box_y = 500; bump_thr = 400;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_corner_boxes();
    test_random_boxes();
    test_backpressure();
    test_no_gaps();
    drain();
    if (mismatches == 0 && ball_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
